@@ hdl/smrc_pkg.sv @@
// ----------------------------------------------------------------------------
// smrc_pkg
// Shared constants and types for the shadow memory range checker.
// ----------------------------------------------------------------------------
`default_nettype none

package smrc_pkg;

    localparam int ADDR_BITS_DEF = 16;
    localparam int GRAN_SHIFT    = 3;
    localparam int GRAN_BITS_DEF = ADDR_BITS_DEF - GRAN_SHIFT;

    localparam int START_W  = 16;
    localparam int LENGTH_W = 17;
    localparam int GIDX_W   = 13;
    localparam int SHADOW_W = 8;
    localparam int WLOW_W   = 16;
    localparam int WHIGH_W  = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_SKIP  = 2'd1;
    localparam t_status STATUS_FAULT = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH  = 2'd2;

    localparam logic [WHIGH_W-1:0] WHIGH_RESET = 17'h10000;

endpackage : smrc_pkg

`default_nettype wire

@@ hdl/shadow_memory_range_check.sv @@
// ----------------------------------------------------------------------------
// shadow_memory_range_check
// Shadow memory range checker, one shadow byte per 8-byte granule.
//
// Usage: present a transaction on the i_cmd/payload ports with start high;
// it is taken at a clock edge where busy is low. A write stores one shadow
// byte; a check tests [i_start_addr, i_start_addr + i_length).
// Each transaction yields one o_status, shown for one cycle with o_valid.
// The receiver cannot stall: o_valid is a single-cycle pulse.
// Reporting: a write, a skipped check or an over-window fault reports in the
// cycle after acceptance. A check that walks n granules reads one shadow
// byte per cycle from the single read port and reports after the last
// granule it reads; busy stays high meanwhile.
// A new transaction may be taken in the cycle its predecessor reports.
// Reset: configuration returns to enabled, full window; a clearing sweep
// then zeroes all 2^(ADDR_BITS-3) shadow table entries (8192 by default),
// with busy high. Configuration writes are taken at any time, including
// during the sweep, and apply to transactions accepted afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module shadow_memory_range_check
    import smrc_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_cmd,
    input  wire logic [START_W-1:0]    i_start_addr,
    input  wire logic [LENGTH_W-1:0]   i_length,
    input  wire logic [GIDX_W-1:0]     i_granule_index,
    input  wire logic [SHADOW_W-1:0]   i_shadow_value,
    output logic                       o_valid,
    output t_status                    o_status
);

    localparam int GW  = ADDR_BITS - GRAN_SHIFT;
    localparam int AMW = (ADDR_BITS < START_W) ? ADDR_BITS : START_W;
    localparam int CW  = LENGTH_W - GRAN_SHIFT;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_WALK  = 3'b100
    } t_state;

    function automatic logic [3:0] allows(input logic [SHADOW_W-1:0] sv);
        logic [3:0] res;
        if (sv == '0) begin
            res = 4'd8;
        end else if (sv <= 8'd7) begin
            res = sv[3:0];
        end else begin
            res = 4'd0;
        end
        return res;
    endfunction

    t_state               r_state, n_state;
    logic                 r_valid, n_valid;
    t_status              r_status, n_status;
    logic [CW-1:0]        r_g, n_g;
    logic [CW-1:0]        r_last, n_last;
    logic [3:0]           r_last_need, n_last_need;
    logic [GW-1:0]        r_clr, n_clr;
    logic                 r_enable;
    logic [WLOW_W-1:0]    r_wlow;
    logic [WHIGH_W-1:0]   r_whigh;

    logic                 w_accept;
    logic [START_W-1:0]   w_addr;
    logic [WHIGH_W-1:0]   w_room;
    logic [LENGTH_W-1:0]  w_end;
    logic [LENGTH_W-1:0]  w_end_m1;
    logic                 w_skip;
    logic                 w_over;
    logic [3:0]           w_need;
    logic                 ram_we;
    logic [GW-1:0]        ram_waddr;
    logic [SHADOW_W-1:0]  ram_wdata;
    logic                 ram_re;
    logic [GW-1:0]        ram_raddr;
    logic [SHADOW_W-1:0]  ram_rdata;

    smrc_shadow_ram #(
        .GRAN_BITS (GW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign o_valid  = r_valid;
    assign o_status = r_status;

    assign w_addr   = START_W'(i_start_addr[AMW-1:0]);
    assign w_room   = r_whigh - {1'b0, w_addr};
    assign w_end    = {1'b0, w_addr} + i_length;
    assign w_end_m1 = w_end - LENGTH_W'(1);
    assign w_skip   = !r_enable || (w_addr == '0) || (i_length == '0)
                      || (w_addr < r_wlow) || ({1'b0, w_addr} >= r_whigh);
    assign w_over   = (i_length > w_room);
    assign w_need   = (r_g == r_last) ? r_last_need : 4'd8;

    always_comb begin
        n_state     = r_state;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_g         = r_g;
        n_last      = r_last;
        n_last_need = r_last_need;
        n_clr       = r_clr;
        ram_we      = 1'b0;
        ram_waddr   = r_clr;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = GW'(r_g);
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_clr  = r_clr + GW'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == CMD_WRITE) begin
                        ram_we    = 1'b1;
                        ram_waddr = GW'(i_granule_index);
                        ram_wdata = i_shadow_value;
                        n_valid   = 1'b1;
                        n_status  = STATUS_OK;
                    end else if (w_skip) begin
                        n_valid  = 1'b1;
                        n_status = STATUS_SKIP;
                    end else if (w_over) begin
                        n_valid  = 1'b1;
                        n_status = STATUS_FAULT;
                    end else begin
                        ram_re      = 1'b1;
                        ram_raddr   = GW'(w_addr[START_W-1:GRAN_SHIFT]);
                        n_g         = CW'(w_addr[START_W-1:GRAN_SHIFT]);
                        n_last      = w_end_m1[LENGTH_W-1:GRAN_SHIFT];
                        n_last_need = {1'b0, w_end_m1[GRAN_SHIFT-1:0]} + 4'd1;
                        n_state     = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (w_need > allows(ram_rdata)) begin
                    n_valid  = 1'b1;
                    n_status = STATUS_FAULT;
                    n_state  = S_IDLE;
                end else if (r_g == r_last) begin
                    n_valid  = 1'b1;
                    n_status = STATUS_OK;
                    n_state  = S_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = GW'(r_g + CW'(1));
                    n_g       = r_g + CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_g         <= n_g;
        r_last      <= n_last;
        r_last_need <= n_last_need;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_wlow   <= '0;
            r_whigh  <= WHIGH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHECK_ENABLE: r_enable <= i_cfg_wdata[0];
                CFG_WINDOW_LOW:   r_wlow   <= i_cfg_wdata[WLOW_W-1:0];
                CFG_WINDOW_HIGH:  r_whigh  <= i_cfg_wdata[WHIGH_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule : shadow_memory_range_check

`default_nettype wire

@@ hdl/smrc_shadow_ram.sv @@
// ----------------------------------------------------------------------------
// smrc_shadow_ram
// Shadow byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module smrc_shadow_ram
    import smrc_pkg::*;
#(
    parameter int GRAN_BITS = GRAN_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [GRAN_BITS-1:0] i_waddr,
    input  wire logic [SHADOW_W-1:0]  i_wdata,
    input  wire logic                 i_re,
    input  wire logic [GRAN_BITS-1:0] i_raddr,
    output logic      [SHADOW_W-1:0]  o_rdata
);

    logic [SHADOW_W-1:0] r_mem [2**GRAN_BITS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : smrc_shadow_ram

`default_nettype wire
